// ===== design/tsbt_pkg.sv =====
// Shared types, constants and saturation helper for the top-k score bound tracker.
`timescale 1ns / 1ps
package tsbt_pkg;

	localparam int unsigned MAX_LISTS_DEF = 16;
	localparam int unsigned LISTS_W       = 5;
	localparam int unsigned SUM_W         = 40;
	localparam int unsigned SCORE_W       = 32;
	localparam int unsigned PADDR_W       = 3;

	localparam logic [LISTS_W-1:0] LISTS_RESET = 5'd16;

	// register word indexes
	localparam logic [PADDR_W-3:0] REG_LISTS_IN_USE = 1'b0;

	// action codes; code 3 behaves as a query
	localparam logic [1:0] ACT_DISCOVER = 2'd0;
	localparam logic [1:0] ACT_UPDATE   = 2'd1;
	localparam logic [1:0] ACT_QUERY    = 2'd2;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic [1:0]                action;
		logic [3:0]                list_index;
		logic signed [SCORE_W-1:0] score_value;
	} in_word_t;

	typedef struct packed {
		logic signed [SUM_W-1:0]   worst_sum;
		logic signed [SUM_W-1:0]   best_sum;
		logic signed [SCORE_W-1:0] entry_score;
		logic                      entry_found;
		logic                      all_found;
		logic                      bad_index;
	} out_word_t;

	// clamp a 42-bit exact sum to the signed 40-bit range
	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W+1:0] v);
		logic signed [SUM_W-1:0] r;
		if (v[SUM_W+1:SUM_W-1] == 3'b000 || v[SUM_W+1:SUM_W-1] == 3'b111) begin
			r = v[SUM_W-1:0];
		end else if (v[SUM_W+1]) begin
			r = SUM_MIN;
		end else begin
			r = SUM_MAX;
		end
		return r;
	endfunction

endpackage

// ===== design/topk_score_bound_tracker.sv =====
// Top level of the top-k score bound tracker: handshake, input and result registers.
`timescale 1ns / 1ps
// Takes one word per cycle unless in_stall is high and returns one result word per
// input word: the word is registered, then the per-list table read-modify-write and
// both saturating sum updates go into the result register. Back-to-back words to the
// same list see each other's updates. The table is reset directly, so no clearing
// pass is needed.
// lists_in_use sits at byte address 0 of the APB port.
module topk_score_bound_tracker
	import tsbt_pkg::*;
#(
	parameter int unsigned MAX_LISTS = MAX_LISTS_DEF
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic               valid_s1;
	in_word_t           word_s1;
	logic               valid_s2;
	out_word_t          word_s2;
	logic               s2_free;
	logic               adv;
	logic [LISTS_W-1:0] lists_in_use;
	out_word_t          res;

	tsbt_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.lists_in_use (lists_in_use)
	);

	tsbt_core #(.MAX_LISTS(MAX_LISTS)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (adv),
		.word         (word_s1),
		.lists_in_use (lists_in_use),
		.res          (res)
	);

	assign s2_free  = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while pipeline has room");

	a_bad_index_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.bad_index) |->
		(!out_word.entry_found && out_word.entry_score == '0))
		else $error("bad index result carries entry data");

	a_discover_stores: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && word_s1.action == ACT_DISCOVER && !res.bad_index) |=>
		(valid_s2 && word_s2.entry_found && word_s2.entry_score == $past(word_s1.score_value)))
		else $error("discover did not record the score");

endmodule

// ===== design/tsbt_apb_regs.sv =====
// APB configuration register holding the number of lists in use.
`timescale 1ns / 1ps
module tsbt_apb_regs
	import tsbt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output logic [LISTS_W-1:0]   lists_in_use
);

	logic [LISTS_W-1:0] lists_q;
	logic               hit;

	assign hit   = (paddr[PADDR_W-1:2] == REG_LISTS_IN_USE);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lists_q <= LISTS_RESET;
		end else if (psel && penable && pwrite && hit) begin
			lists_q <= pwdata[LISTS_W-1:0];
		end
	end

	assign prdata       = hit ? {{(32-LISTS_W){1'b0}}, lists_q} : 32'd0;
	assign lists_in_use = lists_q;

endmodule

// ===== design/tsbt_core.sv =====
// Per-list table, bound sums and combinational read-modify-write of one word, stored on commit.
`timescale 1ns / 1ps
module tsbt_core
	import tsbt_pkg::*;
#(
	parameter int unsigned MAX_LISTS = MAX_LISTS_DEF
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               commit,
	input  in_word_t           word,
	input  logic [LISTS_W-1:0] lists_in_use,
	output out_word_t          res
);

	localparam int unsigned IDX_W = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_LISTS + 1);
	localparam int unsigned CMP_W = (CNT_W > LISTS_W) ? CNT_W : LISTS_W;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_LISTS);

	logic [MAX_LISTS-1:0]            flags_q;
	logic signed [SCORE_W-1:0]       scores_q [MAX_LISTS];
	logic signed [SUM_W-1:0]         lower_q;
	logic signed [SUM_W-1:0]         upper_q;

	logic [CMP_W-1:0]                lists_ext;
	logic [CMP_W-1:0]                n_act;
	logic                            bad;
	logic [IDX_W-1:0]                idx;
	logic signed [SCORE_W-1:0]       old_score;
	logic                            old_found;
	logic                            do_disc;
	logic                            do_upd;
	logic                            wr;
	logic signed [SCORE_W:0]         delta;
	logic signed [SUM_W+1:0]         up_exact;
	logic signed [SUM_W+1:0]         lo_exact;
	logic signed [SUM_W-1:0]         upper_new;
	logic signed [SUM_W-1:0]         lower_new;
	logic [MAX_LISTS-1:0]            flags_new;
	logic                            all;

	assign lists_ext = CMP_W'(lists_in_use);
	assign n_act     = (lists_ext > MAX_CMP) ? MAX_CMP : lists_ext;
	assign bad       = (CMP_W'(word.list_index) >= n_act);
	assign idx       = IDX_W'(word.list_index);
	assign old_score = scores_q[idx];
	assign old_found = flags_q[idx];

	assign do_disc = !bad && (word.action == ACT_DISCOVER);
	assign do_upd  = !bad && (word.action == ACT_UPDATE) && !old_found;
	assign wr      = do_disc || do_upd;

	assign delta    = {word.score_value[SCORE_W-1], word.score_value}
	                - {old_score[SCORE_W-1], old_score};
	assign up_exact = {{2{upper_q[SUM_W-1]}}, upper_q}
	                + {{(SUM_W+1-SCORE_W){delta[SCORE_W]}}, delta};
	assign lo_exact = {{2{lower_q[SUM_W-1]}}, lower_q}
	                + {{(SUM_W+2-SCORE_W){word.score_value[SCORE_W-1]}}, word.score_value};

	assign upper_new = wr      ? sat_sum(up_exact) : upper_q;
	assign lower_new = do_disc ? sat_sum(lo_exact) : lower_q;

	always_comb begin
		all = 1'b1;
		for (int i = 0; i < MAX_LISTS; i++) begin
			flags_new[i] = flags_q[i] || (do_disc && (idx == IDX_W'(i)));
			if (!flags_new[i] && (CMP_W'(i) < n_act)) begin
				all = 1'b0;
			end
		end
	end

	always_comb begin
		res.worst_sum   = lower_new;
		res.best_sum    = upper_new;
		res.entry_score = bad ? '0 : (wr ? word.score_value : old_score);
		res.entry_found = !bad && (old_found || do_disc);
		res.all_found   = all;
		res.bad_index   = bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			lower_q <= '0;
			upper_q <= '0;
			for (int i = 0; i < MAX_LISTS; i++) begin
				scores_q[i] <= '0;
			end
		end else if (commit) begin
			flags_q <= flags_new;
			lower_q <= lower_new;
			upper_q <= upper_new;
			if (wr) begin
				scores_q[idx] <= word.score_value;
			end
		end
	end

endmodule

// ===== tb/sv/tsbt_bound_checker.sv =====
// Bound checker: watches word channels and register port, predicts and compares results.
`timescale 1ns / 1ps
module tsbt_bound_checker
	import tsbt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  in_word_t           in_word,
	input  logic               out_valid,
	input  logic               out_stall,
	input  out_word_t          out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 errors,
	output int                 pending
);

	localparam longint BOUND_HI = 64'sd549755813887;
	localparam longint BOUND_LO = -BOUND_HI - 1;
	localparam logic [PADDR_W-1:0] LISTS_ADDR = {REG_LISTS_IN_USE, 2'b00};

	logic [LISTS_W-1:0]        lists_cfg;
	logic                      found_tbl [MAX_LISTS_DEF];
	logic signed [SCORE_W-1:0] score_tbl [MAX_LISTS_DEF];
	logic signed [SUM_W-1:0]   worst_acc;
	logic signed [SUM_W-1:0]   best_acc;
	out_word_t                 bound_q [$];
	out_word_t                 want;
	int                        miss_count = 0;
	int                        k;

	function automatic logic signed [SUM_W-1:0] clamp_sum(input longint v);
		if (v > BOUND_HI) begin
			return SUM_MAX;
		end
		if (v < BOUND_LO) begin
			return SUM_MIN;
		end
		return v[SUM_W-1:0];
	endfunction

	function automatic out_word_t track_word(input in_word_t w);
		out_word_t    r;
		int unsigned  n;
		int unsigned  idx;
		int unsigned  i;
		longint       delta;
		r = '0;
		n = (lists_cfg > MAX_LISTS_DEF) ? MAX_LISTS_DEF : 32'(lists_cfg);
		idx = 32'(w.list_index);
		r.bad_index = (idx >= n);
		if (!r.bad_index) begin
			if (w.action == ACT_DISCOVER) begin
				delta = longint'(w.score_value) - longint'(score_tbl[idx]);
				best_acc = clamp_sum(longint'(best_acc) + delta);
				worst_acc = clamp_sum(longint'(worst_acc) + longint'(w.score_value));
				found_tbl[idx] = 1'b1;
				score_tbl[idx] = w.score_value;
			end else if (w.action == ACT_UPDATE && !found_tbl[idx]) begin
				delta = longint'(w.score_value) - longint'(score_tbl[idx]);
				best_acc = clamp_sum(longint'(best_acc) + delta);
				score_tbl[idx] = w.score_value;
			end
			r.entry_score = score_tbl[idx];
			r.entry_found = found_tbl[idx];
		end
		r.all_found = 1'b1;
		for (i = 0; i < n; i++) begin
			if (!found_tbl[i]) begin
				r.all_found = 1'b0;
			end
		end
		r.worst_sum = worst_acc;
		r.best_sum = best_acc;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] due);
		$display("%0t mismatch %s: got %h expected %h", $time, what, seen, due);
		miss_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lists_cfg = LISTS_RESET;
			for (k = 0; k < MAX_LISTS_DEF; k++) begin
				found_tbl[k] = 1'b0;
				score_tbl[k] = '0;
			end
			worst_acc = '0;
			best_acc = '0;
			bound_q.delete();
			pending <= 0;
			errors <= miss_count;
		end else begin
			// result words are checked before this edge's input word is queued
			if (out_valid && !out_stall) begin
				if (bound_q.size() == 0) begin
					note_mismatch("result word with none due", 64'(out_word.worst_sum), '0);
				end else begin
					want = bound_q.pop_front();
					if (out_word.worst_sum !== want.worst_sum)
						note_mismatch("worst_sum", 64'(out_word.worst_sum),
							64'(want.worst_sum));
					if (out_word.best_sum !== want.best_sum)
						note_mismatch("best_sum", 64'(out_word.best_sum),
							64'(want.best_sum));
					if (out_word.entry_score !== want.entry_score)
						note_mismatch("entry_score", 64'(out_word.entry_score),
							64'(want.entry_score));
					if (out_word.entry_found !== want.entry_found)
						note_mismatch("entry_found", 64'(out_word.entry_found),
							64'(want.entry_found));
					if (out_word.all_found !== want.all_found)
						note_mismatch("all_found", 64'(out_word.all_found),
							64'(want.all_found));
					if (out_word.bad_index !== want.bad_index)
						note_mismatch("bad_index", 64'(out_word.bad_index),
							64'(want.bad_index));
				end
			end
			if (psel && penable && pwrite && pready && paddr == LISTS_ADDR) begin
				lists_cfg = pwdata[LISTS_W-1:0];
			end
			if (in_valid && !in_stall) begin
				bound_q.push_back(track_word(in_word));
			end
			pending <= bound_q.size();
			errors <= miss_count;
		end
	end

endmodule

// ===== tb/sv/topk_score_bound_tracker_test.sv =====
// Testbench top: clock, reset, stimulus, watchdog and verdict for the bound tracker.
`timescale 1ns / 1ps
module topk_score_bound_tracker_test;
	import tsbt_pkg::*;

	typedef enum int {MIX_SCORES, CLIMB_SCORES, FALL_SCORES} score_bias_t;

	localparam logic [1:0]                ACT_SPARE   = 2'd3;
	localparam logic [PADDR_W-1:0]        LISTS_ADDR  = {REG_LISTS_IN_USE, 2'b00};
	localparam logic signed [SCORE_W-1:0] SCORE_HI    = 32'sh7fffffff;
	localparam logic signed [SCORE_W-1:0] SCORE_LO    = 32'sh80000000;
	localparam int                        STUCK_LIMIT = 2000;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	in_word_t           in_word   = '0;
	logic               out_stall = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [31:0]        pwdata    = '0;
	logic               in_stall;
	logic               out_valid;
	out_word_t          out_word;
	logic [31:0]        prdata;
	logic               pready;
	int                 errors;
	int                 pending;
	int                 gap_pct   = 0;
	int                 stall_pct = 0;
	int                 stuck_cycles;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	topk_score_bound_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	tsbt_bound_checker bounds_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.errors    (errors),
		.pending   (pending)
	);

	task automatic send_word(input in_word_t w);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic poke(input logic [1:0] act, input logic [3:0] idx, input logic signed [31:0] val);
		in_word_t w;
		w.action = act;
		w.list_index = idx;
		w.score_value = val;
		send_word(w);
	endtask

	// drain every pending result word with the input idle, then wait
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_lists(input logic [LISTS_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LISTS_ADDR;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic in_word_t make_word(input score_bias_t bias, input int unsigned span);
		in_word_t w;
		if (span == 0 || $urandom_range(0, 99) < 20) begin
			w.list_index = 4'($urandom_range(0, 15));
		end else begin
			w.list_index = 4'($urandom_range(0, span - 1));
		end
		if (bias != MIX_SCORES && $urandom_range(0, 99) < 80) begin
			w.action = ACT_DISCOVER;
			w.score_value = (bias == CLIMB_SCORES) ? SCORE_HI : SCORE_LO;
		end else begin
			case ($urandom_range(0, 9)) inside
				[0:3]:   w.action = ACT_DISCOVER;
				[4:6]:   w.action = ACT_UPDATE;
				[7:8]:   w.action = ACT_QUERY;
				default: w.action = ACT_SPARE;
			endcase
			case ($urandom_range(0, 7))
				0:       w.score_value = SCORE_HI;
				1:       w.score_value = SCORE_LO;
				2:       w.score_value = '0;
				3:       w.score_value = $signed($urandom_range(0, 255)) - 128;
				default: w.score_value = $urandom;
			endcase
		end
		return w;
	endfunction

	task automatic run_phase(input logic [LISTS_W-1:0] lists, input int count,
			input score_bias_t bias, input int gap, input int stall);
		int unsigned span;
		settle();
		write_lists(lists);
		gap_pct = gap;
		stall_pct = stall;
		span = (lists > MAX_LISTS_DEF) ? MAX_LISTS_DEF : 32'(lists);
		repeat (count) send_word(make_word(bias, span));
	endtask

	initial begin
		stuck_cycles = 0;
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !arst_n) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
		end
		$display("topk_score_bound_tracker verification failed");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the register: sixteen lists
		poke(ACT_QUERY, 4'd0, 32'sd0);
		poke(ACT_UPDATE, 4'd0, SCORE_HI);
		poke(ACT_DISCOVER, 4'd0, SCORE_LO);
		poke(ACT_DISCOVER, 4'd0, SCORE_HI);
		poke(ACT_UPDATE, 4'd0, 32'sd123);
		poke(ACT_SPARE, 4'd0, SCORE_LO);
		poke(ACT_UPDATE, 4'd15, SCORE_LO);
		poke(ACT_DISCOVER, 4'd15, -32'sd1);
		poke(ACT_QUERY, 4'd15, SCORE_HI);

		// two lists: the tail entries are kept but out of range
		settle();
		write_lists(5'd2);
		poke(ACT_QUERY, 4'd1, 32'sd0);
		poke(ACT_DISCOVER, 4'd1, 32'sh00010000);
		poke(ACT_QUERY, 4'd2, 32'sd0);
		poke(ACT_DISCOVER, 4'd15, SCORE_HI);
		poke(ACT_QUERY, 4'd0, 32'sd0);

		// no lists: every index is bad and all are found
		settle();
		write_lists(5'd0);
		poke(ACT_DISCOVER, 4'd0, SCORE_HI);
		poke(ACT_QUERY, 4'd0, 32'sd0);

		// above the table size acts as the full table
		settle();
		write_lists(5'd31);
		poke(ACT_QUERY, 4'd3, 32'sd0);
		poke(ACT_UPDATE, 4'd3, 32'sh7fff0000);
		settle();
		write_lists(5'd17);
		poke(ACT_QUERY, 4'd15, 32'sd0);

		run_phase(5'd16, 330, CLIMB_SCORES, 25, 52);
		run_phase(5'd1, 100, MIX_SCORES, 25, 52);
		run_phase(5'd31, 700, FALL_SCORES, 52, 25);
		run_phase(5'd0, 50, MIX_SCORES, 52, 25);
		run_phase(5'($urandom_range(2, 15)), 200, MIX_SCORES, 0, 0);
		run_phase(5'd16, 100, MIX_SCORES, 0, 0);

		settle();
		repeat (6) @(posedge clk);
		if (errors == 0) begin
			$display("topk_score_bound_tracker verification clean");
		end else begin
			$display("topk_score_bound_tracker verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/tsbt_pkg.sv
design/tsbt_apb_regs.sv
design/tsbt_core.sv
design/topk_score_bound_tracker.sv
tb/sv/tsbt_bound_checker.sv
tb/sv/topk_score_bound_tracker_test.sv
